/* hw/rtl/kdj_pkg.sv */
// ============================================================================
// kdj_pkg - shared types and constants for the KDJ oscillator
// Q8 constants, engine status struct, divide-by-three helper.
// ============================================================================
package kdj_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 24;

  localparam int CFG_W = 7;   // window length register
  localparam int VAL_W = 15;  // unsigned Q8 results
  localparam int J_W   = 18;  // signed J result
  localparam int SUM_W = 17;  // 2*prev + new, up to 76800

  localparam int MIN_WINDOW = 2;

  localparam logic [CFG_W-1:0] WIN_LEN_RESET = 7'd9;

  localparam logic [VAL_W-1:0] Q8_FIFTY   = 15'd12800;
  localparam logic [VAL_W-1:0] Q8_HUNDRED = 15'd25600;

  // ceil(2^17 / 3); exact floor(x/3) for every x below 2^17
  localparam logic [SUM_W-1:0] DIV3_RECIP = 17'd43691;

  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  function automatic logic [VAL_W-1:0] div3(input logic [SUM_W-1:0] x);
    logic [2*SUM_W-1:0] p;
    p = {{SUM_W{1'b0}}, x} * {{SUM_W{1'b0}}, DIV3_RECIP};
    return p[SUM_W+VAL_W-1:SUM_W];
  endfunction

endpackage

/* hw/rtl/kdj_store.sv */
// ============================================================================
// kdj_store - bar history memory with window max/min scanner
// One write port for new bars, one registered read port walked backward.
// ============================================================================
module kdj_store #(
  parameter int MAX_WINDOW = kdj_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = kdj_pkg::PRICE_BITS_DEF,
  localparam int ADDR_W = $clog2(MAX_WINDOW),
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [PRICE_BITS-1:0] wr_high,
  input  logic [PRICE_BITS-1:0] wr_low,
  input  logic                  scan_start,
  input  logic [CNT_W-1:0]      scan_len,
  output kdj_pkg::eng_stat_t    scan_stat,
  output logic [PRICE_BITS-1:0] win_high,
  output logic [PRICE_BITS-1:0] win_low
);

  logic [2*PRICE_BITS-1:0] mem_r [MAX_WINDOW];
  logic [2*PRICE_BITS-1:0] rd_data_r;

  logic              busy_r;
  logic              pend_r;
  logic [CNT_W-1:0]  left_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [PRICE_BITS-1:0] max_r;
  logic [PRICE_BITS-1:0] min_r;

  logic rd_en;
  logic done;
  logic [PRICE_BITS-1:0] rd_high;
  logic [PRICE_BITS-1:0] rd_low;

  function automatic logic [ADDR_W-1:0] prev_addr(input logic [ADDR_W-1:0] a);
    return (a == '0) ? ADDR_W'(MAX_WINDOW - 1) : a - 1'b1;
  endfunction

  assign rd_en   = busy_r && (left_r != '0);
  assign done    = busy_r && (left_r == '0) && !pend_r;
  assign rd_high = rd_data_r[2*PRICE_BITS-1:PRICE_BITS];
  assign rd_low  = rd_data_r[PRICE_BITS-1:0];

  // newest bar is seeded straight from the write data; the scan reads
  // only older entries, so it never touches the slot written this edge
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_high, wr_low};
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pend_r    <= 1'b0;
      left_r    <= '0;
      rd_addr_r <= '0;
    end else if (scan_start) begin
      busy_r    <= 1'b1;
      pend_r    <= 1'b0;
      left_r    <= scan_len - 1'b1;
      rd_addr_r <= prev_addr(wr_addr);
    end else if (busy_r) begin
      pend_r <= rd_en;
      if (rd_en) begin
        left_r    <= left_r - 1'b1;
        rd_addr_r <= prev_addr(rd_addr_r);
      end
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      max_r <= wr_high;
      min_r <= wr_low;
    end else if (pend_r) begin
      if (rd_high > max_r) max_r <= rd_high;
      if (rd_low < min_r)  min_r <= rd_low;
    end
  end

  assign scan_stat.busy = busy_r;
  assign scan_stat.done = done;
  assign win_high       = max_r;
  assign win_low        = min_r;

endmodule

/* hw/rtl/kdj_rsv_div.sv */
// ============================================================================
// kdj_rsv_div - serial divider for the raw stochastic value
// quo = floor(num * 25600 / den), one quotient bit per cycle; needs num < den.
// ============================================================================
module kdj_rsv_div #(
  parameter int PRICE_BITS = kdj_pkg::PRICE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [PRICE_BITS-1:0]      num,
  input  logic [PRICE_BITS-1:0]      den,
  output kdj_pkg::eng_stat_t         stat,
  output logic [kdj_pkg::VAL_W-1:0]  quo
);

  localparam int Q_BITS   = kdj_pkg::VAL_W;
  localparam int FRAC_SH  = 8;                  // 25600 = 100 << 8
  localparam int LOW_BITS = Q_BITS - FRAC_SH;
  localparam int PROD_W   = PRICE_BITS + 7;     // num * 100
  localparam int CNT_W    = $clog2(Q_BITS + 2);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] prod_r;
  logic [PRICE_BITS-1:0] den_r;
  logic [PRICE_BITS-1:0] rem_r;
  logic [Q_BITS-1:0] sh_r;
  logic [Q_BITS-1:0] q_r;

  logic [PROD_W-1:0]   num_ext;
  logic [PROD_W-1:0]   prod_nxt;
  logic [PRICE_BITS:0] trial;
  logic [PRICE_BITS:0] diff;
  logic                ge;
  logic                load;

  assign num_ext  = PROD_W'(num);
  assign prod_nxt = (num_ext << 6) + (num_ext << 5) + (num_ext << 2);
  assign trial    = {rem_r, sh_r[Q_BITS-1]};
  assign diff     = trial - {1'b0, den_r};
  assign ge       = (trial >= {1'b0, den_r});
  assign load     = busy_r && (cnt_r == CNT_W'(Q_BITS + 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(Q_BITS + 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // quotient fits in Q_BITS, so the top part of the dividend is below den
  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
      den_r  <= den;
    end else if (load) begin
      rem_r <= prod_r[PROD_W-1:LOW_BITS];
      sh_r  <= {prod_r[LOW_BITS-1:0], {FRAC_SH{1'b0}}};
      q_r   <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= ge ? diff[PRICE_BITS-1:0] : trial[PRICE_BITS-1:0];
      sh_r  <= sh_r << 1;
      q_r   <= {q_r[Q_BITS-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == '0);
  assign quo       = q_r;

endmodule

/* hw/rtl/kdj_stochastic_oscillator.sv */
// ============================================================================
// kdj_stochastic_oscillator - KDJ stochastic oscillator, Q8 fixed point
// Stores bar highs/lows, scans the lookback window, forms RSV, K, D and J.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in_     | request   | in_valid / in_stall  | bar_high, bar_low, bar_close
//  out_    | result    | out_valid / out_stall| rsv, k, d, j, warming_up
//  cfg_    | write     | cfg_valid / cfg_ready| window_length (7 bits)
//
//  One request at a time. Warm-up requests skip the scan and go straight to
//  loading the output register; full-window requests first run the window
//  scan over the clamped window length (one read per cycle) and the 15-step
//  RSV divider, which is skipped when the RSV needs no divide.
//  rst_n is synchronous; history memory has no reset and is never read
//  before written. A stalled result sits in the output register while the
//  next request is already accepted and worked on.
// ============================================================================
module kdj_stochastic_oscillator #(
  parameter int MAX_WINDOW = kdj_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = kdj_pkg::PRICE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [PRICE_BITS-1:0]             in_bar_high,
  input  logic [PRICE_BITS-1:0]             in_bar_low,
  input  logic [PRICE_BITS-1:0]             in_bar_close,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [kdj_pkg::VAL_W-1:0]         out_rsv_value,
  output logic [kdj_pkg::VAL_W-1:0]         out_k_value,
  output logic [kdj_pkg::VAL_W-1:0]         out_d_value,
  output logic signed [kdj_pkg::J_W-1:0]    out_j_value,
  output logic                              out_warming_up,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kdj_pkg::CFG_W-1:0]         cfg_window_length
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int VAL_W  = kdj_pkg::VAL_W;
  localparam int J_W    = kdj_pkg::J_W;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SCAN = 8'b0000_0010,
    ST_RSV  = 8'b0000_0100,  // register |num|, |den| and special-case flags
    ST_CMP  = 8'b0000_1000,  // pick RSV directly or launch the divider
    ST_DIV  = 8'b0001_0000,
    ST_K    = 8'b0010_0000,
    ST_D    = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [kdj_pkg::CFG_W-1:0] cfg_len_r;
  logic [ADDR_W-1:0]         slot_r;
  logic [CNT_W-1:0]          bars_r;
  logic [VAL_W-1:0]          prev_k_r;
  logic [VAL_W-1:0]          prev_d_r;
  logic                      warm_r;

  logic [PRICE_BITS-1:0] close_r;
  logic [PRICE_BITS-1:0] num_r;
  logic [PRICE_BITS-1:0] den_r;
  logic                  flat_r;
  logic                  zero_r;
  logic [VAL_W-1:0]      rsv_r;
  logic [VAL_W-1:0]      k_r;

  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_rsv_r;
  logic [VAL_W-1:0]      out_k_r;
  logic [VAL_W-1:0]      out_d_r;
  logic signed [J_W-1:0] out_j_r;
  logic                  out_warm_r;

  logic                  accept;
  logic [CNT_W-1:0]      eff_len;
  logic [CNT_W-1:0]      bars_nxt;
  logic                  warm_nxt;
  logic                  scan_start;
  logic                  div_start;
  logic                  out_load;
  logic [PRICE_BITS-1:0] win_high;
  logic [PRICE_BITS-1:0] win_low;
  logic                  num_neg;
  logic                  den_neg;
  logic [PRICE_BITS-1:0] num_abs;
  logic [PRICE_BITS-1:0] den_abs;
  logic [kdj_pkg::SUM_W-1:0] sm_sum;
  logic [VAL_W-1:0]      div_quo;
  logic signed [J_W-1:0] j_calc;

  kdj_pkg::eng_stat_t scan_stat;
  kdj_pkg::eng_stat_t div_stat;

  // --------------------------------------------------------------------------
  // Request side: one bar in flight, engine busy stalls the input
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // effective window: register clamped to MIN_WINDOW..MAX_WINDOW
  always_comb begin
    if (32'(cfg_len_r) < 32'(kdj_pkg::MIN_WINDOW)) begin
      eff_len = CNT_W'(kdj_pkg::MIN_WINDOW);
    end else if (32'(cfg_len_r) > 32'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(cfg_len_r);
    end
  end

  // bar count saturates at the memory depth
  assign bars_nxt   = (bars_r < CNT_W'(MAX_WINDOW)) ? bars_r + 1'b1 : bars_r;
  assign warm_nxt   = (bars_nxt < eff_len);
  assign scan_start = accept && !warm_nxt;

  // --------------------------------------------------------------------------
  // History memory and window scan
  // --------------------------------------------------------------------------
  kdj_store #(
    .MAX_WINDOW (MAX_WINDOW),
    .PRICE_BITS (PRICE_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (accept),
    .wr_addr    (slot_r),
    .wr_high    (in_bar_high),
    .wr_low     (in_bar_low),
    .scan_start (scan_start),
    .scan_len   (eff_len),
    .scan_stat  (scan_stat),
    .win_high   (win_high),
    .win_low    (win_low)
  );

  // --------------------------------------------------------------------------
  // RSV operands. Signs handled as magnitudes; opposite signs or a zero
  // numerator give RSV 0, a quotient of 100 or more saturates.
  // --------------------------------------------------------------------------
  assign num_neg = (close_r < win_low);
  assign num_abs = num_neg ? (win_low - close_r) : (close_r - win_low);
  assign den_neg = (win_high < win_low);
  assign den_abs = den_neg ? (win_low - win_high) : (win_high - win_low);

  assign div_start = (state_r == ST_CMP) && !flat_r && !zero_r && (num_r < den_r);

  kdj_rsv_div #(
    .PRICE_BITS (PRICE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // --------------------------------------------------------------------------
  // Smoothing: one shared divide-by-three multiplier, K then D
  // --------------------------------------------------------------------------
  always_comb begin
    if (state_r == ST_K) begin
      sm_sum = {1'b0, prev_k_r, 1'b0} + {2'b0, rsv_r};
    end else begin
      sm_sum = {1'b0, prev_d_r, 1'b0} + {2'b0, k_r};
    end
  end

  // J = 3K - 2D from the freshly updated K and D
  assign j_calc = $signed({3'b0, prev_k_r}) + $signed({2'b0, prev_k_r, 1'b0})
                - $signed({2'b0, prev_d_r, 1'b0});

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = warm_nxt ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_stat.done) state_nxt = ST_RSV;
      end
      ST_RSV: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = div_start ? ST_DIV : ST_K;
      end
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_K;
      end
      ST_K: begin
        state_nxt = ST_D;
      end
      ST_D: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cfg_len_r <= kdj_pkg::WIN_LEN_RESET;
      slot_r    <= '0;
      bars_r    <= '0;
      prev_k_r  <= kdj_pkg::Q8_FIFTY;
      prev_d_r  <= kdj_pkg::Q8_FIFTY;
      warm_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_len_r <= cfg_window_length;
      end
      if (accept) begin
        slot_r <= (slot_r == ADDR_W'(MAX_WINDOW - 1)) ? '0 : slot_r + 1'b1;
        bars_r <= bars_nxt;
        warm_r <= warm_nxt;
      end
      // K and D history only moves on a full window
      if (state_r == ST_D) begin
        prev_k_r <= k_r;
        prev_d_r <= kdj_pkg::div3(sm_sum);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      close_r <= in_bar_close;
    end
    if (state_r == ST_RSV) begin
      flat_r <= (win_high == '0) || (win_high == win_low);
      zero_r <= (num_abs == '0) || (num_neg != den_neg);
      num_r  <= num_abs;
      den_r  <= den_abs;
    end
    if (state_r == ST_CMP) begin
      if (flat_r) begin
        rsv_r <= kdj_pkg::Q8_FIFTY;
      end else if (zero_r) begin
        rsv_r <= '0;
      end else if (num_r >= den_r) begin
        rsv_r <= kdj_pkg::Q8_HUNDRED;
      end
    end
    if ((state_r == ST_DIV) && div_stat.done) begin
      rsv_r <= div_quo;
    end
    if (state_r == ST_K) begin
      k_r <= kdj_pkg::div3(sm_sum);
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (warm_r) begin
        out_rsv_r <= kdj_pkg::Q8_FIFTY;
        out_k_r   <= kdj_pkg::Q8_FIFTY;
        out_d_r   <= kdj_pkg::Q8_FIFTY;
        out_j_r   <= $signed({3'b0, kdj_pkg::Q8_FIFTY});
      end else begin
        out_rsv_r <= rsv_r;
        out_k_r   <= prev_k_r;
        out_d_r   <= prev_d_r;
        out_j_r   <= j_calc;
      end
      out_warm_r <= warm_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rsv_value  = out_rsv_r;
  assign out_k_value    = out_k_r;
  assign out_d_value    = out_d_r;
  assign out_j_value    = out_j_r;
  assign out_warming_up = out_warm_r;

`ifndef SYNTHESIS
  // accepted bar locks the memory against the next write until done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request accepted while engine was not locked");

  a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    scan_stat.done |-> (state_r == ST_SCAN))
    else $error("window scan finished outside the scan state");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_rsv_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_K) |-> (rsv_r <= kdj_pkg::Q8_HUNDRED))
    else $error("RSV above 100");

  a_warm_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_warming_up) |->
      (out_k_value == kdj_pkg::Q8_FIFTY) && (out_d_value == kdj_pkg::Q8_FIFTY))
    else $error("warm-up result not fixed at 50");
`endif

endmodule

/* sim/kdj_checker.sv */
// ============================================================================
// kdj_checker - result predictor and scoreboard for the KDJ oscillator
// Watches the request, result and window-length channels, runs its own
// model of the oscillator on every accepted bar and compares the results.
// ============================================================================
module kdj_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [kdj_pkg::PRICE_BITS_DEF-1:0]   in_bar_high,
  input  logic [kdj_pkg::PRICE_BITS_DEF-1:0]   in_bar_low,
  input  logic [kdj_pkg::PRICE_BITS_DEF-1:0]   in_bar_close,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [kdj_pkg::VAL_W-1:0]            out_rsv_value,
  input  logic [kdj_pkg::VAL_W-1:0]            out_k_value,
  input  logic [kdj_pkg::VAL_W-1:0]            out_d_value,
  input  logic signed [kdj_pkg::J_W-1:0]       out_j_value,
  input  logic                                 out_warming_up,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [kdj_pkg::CFG_W-1:0]            cfg_window_length,
  output int                                   mismatches,
  output int                                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW     = kdj_pkg::PRICE_BITS_DEF;
  localparam int DEPTH  = kdj_pkg::MAX_WINDOW_DEF;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int VAL_W  = kdj_pkg::VAL_W;
  localparam int J_W    = kdj_pkg::J_W;
  localparam int CFG_W  = kdj_pkg::CFG_W;

  typedef struct packed {
    logic [VAL_W-1:0]      rsv;
    logic [VAL_W-1:0]      k;
    logic [VAL_W-1:0]      d;
    logic signed [J_W-1:0] j;
    logic                  warm;
  } kdj_result_t;

  // model state
  logic [CFG_W-1:0]  win_len;
  logic [PW-1:0]     high_hist [DEPTH];
  logic [PW-1:0]     low_hist  [DEPTH];
  logic [SLOT_W-1:0] next_slot;
  int unsigned       bars_held;
  logic [VAL_W-1:0]  k_last;
  logic [VAL_W-1:0]  d_last;

  kdj_result_t pending_kdj [$];
  int          fail_count = 0;

  assign mismatches = fail_count;

  function automatic logic [VAL_W-1:0] stoch_rsv(input longint unsigned w_hi, w_lo, cl);
    longint unsigned num, den, q;
    bit num_neg, den_neg;
    if (w_hi == 0 || w_hi == w_lo) return kdj_pkg::Q8_FIFTY;
    num_neg = cl < w_lo;
    num     = num_neg ? (w_lo - cl) : (cl - w_lo);
    den_neg = w_hi < w_lo;
    den     = den_neg ? (w_lo - w_hi) : (w_hi - w_lo);
    if (num == 0 || num_neg != den_neg) return '0;
    q = (num * kdj_pkg::Q8_HUNDRED) / den;
    if (q > kdj_pkg::Q8_HUNDRED) q = kdj_pkg::Q8_HUNDRED;
    return q[VAL_W-1:0];
  endfunction

  // store the bar, then form RSV/K/D/J over the newest span entries, or give the warm-up result
  function automatic kdj_result_t advance_kdj(input logic [PW-1:0] bh, bl, bc);
    kdj_result_t       r;
    int unsigned       span;
    logic [SLOT_W-1:0] newest;
    logic [SLOT_W-1:0] idx;
    logic [PW-1:0]     w_hi, w_lo;
    int unsigned       k_new, d_new;
    int                j_new;
    span = win_len;
    if (span < kdj_pkg::MIN_WINDOW) span = kdj_pkg::MIN_WINDOW;
    if (span > DEPTH) span = DEPTH;
    newest = next_slot;
    high_hist[newest] = bh;
    low_hist[newest]  = bl;
    next_slot = newest + 1'b1;
    if (bars_held < DEPTH) bars_held++;
    if (bars_held < span) begin
      r.rsv  = kdj_pkg::Q8_FIFTY;
      r.k    = kdj_pkg::Q8_FIFTY;
      r.d    = kdj_pkg::Q8_FIFTY;
      r.j    = J_W'(kdj_pkg::Q8_FIFTY);
      r.warm = 1'b1;
      return r;
    end
    w_hi = high_hist[newest];
    w_lo = low_hist[newest];
    for (int i = 1; i < span; i++) begin
      idx = newest - SLOT_W'(i);
      if (high_hist[idx] > w_hi) w_hi = high_hist[idx];
      if (low_hist[idx] < w_lo) w_lo = low_hist[idx];
    end
    r.rsv  = stoch_rsv(w_hi, w_lo, bc);
    k_new  = (2 * k_last + r.rsv) / 3;
    d_new  = (2 * d_last + k_new) / 3;
    j_new  = 3 * int'(k_new) - 2 * int'(d_new);
    k_last = k_new[VAL_W-1:0];
    d_last = d_new[VAL_W-1:0];
    r.k    = k_new[VAL_W-1:0];
    r.d    = d_new[VAL_W-1:0];
    r.j    = j_new[J_W-1:0];
    r.warm = 1'b0;
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    kdj_result_t want;
    if (!rst_n) begin
      win_len   = kdj_pkg::WIN_LEN_RESET;
      next_slot = '0;
      bars_held = 0;
      k_last    = kdj_pkg::Q8_FIFTY;
      d_last    = kdj_pkg::Q8_FIFTY;
      pending_kdj.delete();
    end else begin
      // results before requests: a bar accepted now cannot leave this cycle
      if (out_valid && !out_stall) begin
        if (pending_kdj.size() == 0) begin
          $display("%0t ns: result expected none, actual rsv %0d k %0d d %0d j %0d warm %0b",
                   $time, out_rsv_value, out_k_value, out_d_value, out_j_value,
                   out_warming_up);
          fail_count++;
        end else begin
          want = pending_kdj.pop_front();
          check_field("rsv_value", want.rsv, out_rsv_value);
          check_field("k_value", want.k, out_k_value);
          check_field("d_value", want.d, out_d_value);
          check_field("j_value", want.j, out_j_value);
          check_field("warming_up", want.warm, out_warming_up);
        end
      end
      if (in_valid && !in_stall)
        pending_kdj.push_back(advance_kdj(in_bar_high, in_bar_low, in_bar_close));
      // a length write takes effect from the next bar on
      if (cfg_valid && cfg_ready) win_len = cfg_window_length;
    end
    outstanding <= pending_kdj.size();
  end

endmodule

/* sim/testbench.sv */
// ============================================================================
// testbench - top level for the KDJ stochastic oscillator
// Drives price bars and window-length writes with random idle cycles and
// result backpressure; kdj_checker predicts and scores every result.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     PW        = kdj_pkg::PRICE_BITS_DEF;
  localparam int     VAL_W     = kdj_pkg::VAL_W;
  localparam int     J_W       = kdj_pkg::J_W;
  localparam int     CFG_W     = kdj_pkg::CFG_W;
  localparam longint PRICE_MAX = (longint'(1) << PW) - 1;
  localparam int     BAR_COUNT = 1750;   // random bars after the directed part

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PW-1:0]         in_bar_high;
  logic [PW-1:0]         in_bar_low;
  logic [PW-1:0]         in_bar_close;
  logic                  out_valid;
  logic                  out_stall;
  logic [VAL_W-1:0]      out_rsv_value;
  logic [VAL_W-1:0]      out_k_value;
  logic [VAL_W-1:0]      out_d_value;
  logic signed [J_W-1:0] out_j_value;
  logic                  out_warming_up;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_window_length;

  int mismatches;
  int outstanding;

  // traffic shaping, written only by the stimulus process
  logic quiet;        // no idle cycles on either side
  logic squeeze_on;   // ask for the one long result hold-off

  kdj_stochastic_oscillator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_bar_high       (in_bar_high),
    .in_bar_low        (in_bar_low),
    .in_bar_close      (in_bar_close),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rsv_value     (out_rsv_value),
    .out_k_value       (out_k_value),
    .out_d_value       (out_d_value),
    .out_j_value       (out_j_value),
    .out_warming_up    (out_warming_up),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length)
  );

  kdj_checker scoreboard (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_bar_high       (in_bar_high),
    .in_bar_low        (in_bar_low),
    .in_bar_close      (in_bar_close),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rsv_value     (out_rsv_value),
    .out_k_value       (out_k_value),
    .out_d_value       (out_d_value),
    .out_j_value       (out_j_value),
    .out_warming_up    (out_warming_up),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  // 50 MHz
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous ceiling: the slowest legal run (every bar at the 64-entry window,
  // plus stalls) is about 4 ms.
  initial begin : watchdog
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side. Random stalls at ~18%, none while quiet, and one long
  // hold-off so the block fills and pushes back on requests.
  initial begin : result_backpressure
    int hold_left;
    bit squeeze_done;
    hold_left    = 0;
    squeeze_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_on && !squeeze_done) begin
        hold_left    = 600;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 18);
      end
    end
  end

  // One request per call. An optional idle gap comes first, so valid is
  // only ever lowered in a step where it is not also raised.
  task automatic send_bar(input logic [PW-1:0] bh, bl, bc);
    if (!quiet && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_bar_high  <= bh;
    in_bar_low   <= bl;
    in_bar_close <= bc;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait for every predicted result to come back.
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Window length changes only with the block idle.
  task automatic set_window_length(input logic [CFG_W-1:0] len);
    drain_requests();
    repeat (4) @(posedge clk);
    cfg_window_length <= len;
    cfg_valid         <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int          bars_sent;
    int          phase;
    int          phase_bars;
    int unsigned roll;
    int unsigned spread;
    int unsigned span;
    logic [CFG_W-1:0] len;
    longint      lvl, hi, lo, cl, tmp;

    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_bar_high       <= '0;
    in_bar_low        <= '0;
    in_bar_close      <= '0;
    cfg_valid         <= 1'b0;
    cfg_window_length <= '0;
    quiet             <= 1'b0;
    squeeze_on        <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset window length (9) ---
    // widest possible bar while warming up
    send_bar('1, '0, '1);
    for (int i = 0; i < 7; i++)
      send_bar(PW'(1000 + 10 * i), PW'(900 - 5 * i), PW'(950 + i));
    // first full window: K and D start from 50
    send_bar(PW'(2000), PW'(500), PW'(1200));
    // close under the window low, then above the window high
    send_bar(PW'(1500), PW'(800), '0);
    send_bar(PW'(1500), PW'(800), '1);

    // --- directed, length 0 (clamps to 2) ---
    set_window_length('0);
    // flat window
    send_bar(PW'(5000), PW'(5000), PW'(5000));
    send_bar(PW'(5000), PW'(5000), PW'(5000));
    // window high of zero
    send_bar('0, '0, PW'(7));
    send_bar('0, '0, '0);
    // inverted bars: window high below window low
    send_bar(PW'(100), PW'(300), PW'(50));
    send_bar(PW'(120), PW'(400), PW'(60));
    send_bar(PW'(110), PW'(350), PW'(200));
    // price extremes
    send_bar('1, '1, '1);
    send_bar('1, '0, '0);
    send_bar('0, '1, PW'(24'h800000));

    // --- random phases, each with its own window length ---
    bars_sent = 0;
    phase     = 0;
    lvl       = PRICE_MAX / 2;
    while (bars_sent < BAR_COUNT) begin
      case (phase)
        0:       len = 7'd127;
        1:       len = 7'd1;
        2:       len = 7'd64;
        3:       len = 7'd65;
        4:       len = 7'd2;
        default: len = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 127))
                                                   : CFG_W'($urandom_range(0, 20));
      endcase
      set_window_length(len);
      span = (len < kdj_pkg::MIN_WINDOW) ? kdj_pkg::MIN_WINDOW : len;
      if (span > kdj_pkg::MAX_WINDOW_DEF) span = kdj_pkg::MAX_WINDOW_DEF;
      // long windows are slow, so they get fewer bars
      phase_bars = (span >= 40) ? 50 : 140;
      if (phase == 4) squeeze_on <= 1'b1;
      quiet <= (phase == 6);

      for (int n = 0; n < phase_bars; n++) begin
        // mostly a wandering market: low <= close <= high
        roll = $urandom_range(0, 99);
        if (roll < 2) lvl = $urandom_range(0, PRICE_MAX);
        else if (roll < 4) lvl = (roll == 2) ? 0 : PRICE_MAX;
        lvl = lvl + longint'($urandom_range(0, 200)) - 100;
        if (lvl < 0) lvl = 0;
        if (lvl > PRICE_MAX) lvl = PRICE_MAX;
        spread = $urandom_range(0, 1 << $urandom_range(0, 12));
        lo = lvl - longint'($urandom_range(0, spread));
        hi = lvl + longint'($urandom_range(0, spread));
        if (lo < 0) lo = 0;
        if (hi > PRICE_MAX) hi = PRICE_MAX;
        cl = lo + longint'($urandom_range(0, hi - lo));

        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          // pure noise over the full field range
          hi = $urandom_range(0, PRICE_MAX);
          lo = $urandom_range(0, PRICE_MAX);
          cl = $urandom_range(0, PRICE_MAX);
        end else if (roll < 13) begin
          // inverted bar
          tmp = hi;
          hi  = lo;
          lo  = tmp;
        end else if (roll < 18) begin
          // close outside its own bar
          if (roll[0]) cl = (lo > 50) ? lo - 50 : 0;
          else         cl = (hi < PRICE_MAX - 50) ? hi + 50 : PRICE_MAX;
        end else if (roll < 21) begin
          // flat bar
          hi = lvl;
          lo = lvl;
          cl = lvl;
        end else if (roll < 23) begin
          hi = 0;
          lo = 0;
        end
        send_bar(hi[PW-1:0], lo[PW-1:0], cl[PW-1:0]);
        bars_sent++;
      end
      phase++;
    end

    // let the last results out, then wait with the inputs quiet
    drain_requests();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/kdj_pkg.sv
hw/rtl/kdj_store.sv
hw/rtl/kdj_rsv_div.sv
hw/rtl/kdj_stochastic_oscillator.sv
sim/kdj_checker.sv
sim/testbench.sv
